/* rtl/assert_macros.svh */
// Assertion helpers for the RTL (included by tbpc_classify)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TBPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define TBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/tbpc_pkg.sv */
`timescale 1ns / 1ps

package tbpc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_REPEAT_DELAY = 2'd1,
        REG_REPEAT_PER   = 2'd2,
        REG_LONG_PRESS   = 2'd3
    } t_reg_idx;

    // Event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SCROLL = 2'd1,
        EV_SHORT  = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_PER_RST   = 16'd150;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] repeat_delay_ms;
        logic [CFG_W-1:0] repeat_period_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    // Debounced edge seen on this poll
    typedef struct packed {
        logic press;
        logic release_evt;
    } t_deb_evt;

endpackage

/* rtl/tbpc_cfg.sv */
`timescale 1ns / 1ps

module tbpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [tbpc_pkg::DATA_W-1:0]    pwdata,
    output logic [tbpc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output tbpc_pkg::t_cfg                 o_cfg
);
    import tbpc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= DEBOUNCE_RST;
            r_cfg.repeat_delay_ms  <= REPEAT_DELAY_RST;
            r_cfg.repeat_period_ms <= REPEAT_PER_RST;
            r_cfg.long_press_ms    <= LONG_PRESS_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DEBOUNCE:     r_cfg.debounce_ms      <= pwdata[CFG_W-1:0];
                REG_REPEAT_DELAY: r_cfg.repeat_delay_ms  <= pwdata[CFG_W-1:0];
                REG_REPEAT_PER:   r_cfg.repeat_period_ms <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS:   r_cfg.long_press_ms    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        case (idx)
            REG_DEBOUNCE:     prdata[CFG_W-1:0] = r_cfg.debounce_ms;
            REG_REPEAT_DELAY: prdata[CFG_W-1:0] = r_cfg.repeat_delay_ms;
            REG_REPEAT_PER:   prdata[CFG_W-1:0] = r_cfg.repeat_period_ms;
            REG_LONG_PRESS:   prdata[CFG_W-1:0] = r_cfg.long_press_ms;
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/tbpc_debounce.sv */
`timescale 1ns / 1ps

module tbpc_debounce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [tbpc_pkg::TIME_W-1:0]  i_now,
    input  logic                         i_level,
    input  logic [tbpc_pkg::CFG_W-1:0]   i_debounce_ms,
    output tbpc_pkg::t_deb_evt           o_evt
);
    import tbpc_pkg::*;

    logic              r_last_raw;
    logic              r_stable;
    logic [TIME_W-1:0] r_change_time;

    logic              changed;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] elapsed;
    logic              take;

    // A raw change restarts the window; level is taken once the window is exceeded
    always_comb begin
        changed     = i_level != r_last_raw;
        change_time = changed ? i_now : r_change_time;
        elapsed     = i_now - change_time;
        take        = (elapsed > {{(TIME_W-CFG_W){1'b0}}, i_debounce_ms})
                      && (i_level != r_stable);
        o_evt.press       = take && !i_level;
        o_evt.release_evt = take && i_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b1;
            r_stable      <= 1'b1;
            r_change_time <= '0;
        end else if (i_en) begin
            r_last_raw    <= i_level;
            r_change_time <= change_time;
            if (take) begin
                r_stable <= i_level;
            end
        end
    end

endmodule

/* rtl/tbpc_classify.sv */
`timescale 1ns / 1ps

module tbpc_classify (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [tbpc_pkg::TIME_W-1:0]  i_now,
    input  tbpc_pkg::t_cfg               i_cfg,
    input  tbpc_pkg::t_deb_evt           i_scroll,
    input  tbpc_pkg::t_deb_evt           i_select,
    output logic                         o_select_en,
    output tbpc_pkg::t_event             o_event
);
    import tbpc_pkg::*;
    `include "assert_macros.svh"

    logic              r_scroll_held;
    logic [TIME_W-1:0] r_scroll_press_time;
    logic [TIME_W-1:0] r_scroll_repeat_time;
    logic              r_select_held;
    logic [TIME_W-1:0] r_select_press_time;
    logic              r_long_sent;

    logic              n_scroll_held;
    logic              scroll_repeat;
    logic              scroll_ev;
    logic              n_select_held;
    logic [TIME_W-1:0] n_select_press_time;
    logic              sent_a;
    logic              short_ev;
    logic              long_ev;
    logic              n_long_sent;

    // Scroll: event on debounced press, then auto-repeat while held
    always_comb begin
        n_scroll_held = i_scroll.press ? 1'b1 :
                        (i_scroll.release_evt ? 1'b0 : r_scroll_held);
        scroll_repeat = r_scroll_held && !i_scroll.press && !i_scroll.release_evt
            && ((i_now - r_scroll_press_time)
                >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_delay_ms})
            && ((i_now - r_scroll_repeat_time)
                >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_period_ms});
        scroll_ev     = i_scroll.press || scroll_repeat;
    end

    // Select: short press on release unless a long press was sent, long press once while held
    always_comb begin
        n_select_held       = i_select.press ? 1'b1 :
                              (i_select.release_evt ? 1'b0 : r_select_held);
        n_select_press_time = i_select.press ? i_now : r_select_press_time;
        sent_a              = i_select.press ? 1'b0 : r_long_sent;
        short_ev            = i_select.release_evt && r_select_held && !r_long_sent;
        long_ev             = !short_ev && n_select_held && !sent_a
            && ((i_now - n_select_press_time)
                >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms});
        n_long_sent         = long_ev ? 1'b1 : sent_a;
    end

    assign o_select_en = i_fire && !scroll_ev;

    always_comb begin
        if (scroll_ev) begin
            o_event = EV_SCROLL;
        end else if (short_ev) begin
            o_event = EV_SHORT;
        end else if (long_ev) begin
            o_event = EV_LONG;
        end else begin
            o_event = EV_NONE;
        end
    end

    // Scroll state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_held        <= 1'b0;
            r_scroll_press_time  <= '0;
            r_scroll_repeat_time <= '0;
        end else if (i_fire) begin
            r_scroll_held <= n_scroll_held;
            if (i_scroll.press) begin
                r_scroll_press_time <= i_now;
            end
            if (scroll_ev) begin
                r_scroll_repeat_time <= i_now;
            end
        end
    end

    // Select state, frozen on polls that scroll claims
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_held       <= 1'b0;
            r_select_press_time <= '0;
            r_long_sent         <= 1'b0;
        end else if (o_select_en) begin
            r_select_held       <= n_select_held;
            r_select_press_time <= n_select_press_time;
            r_long_sent         <= n_long_sent;
        end
    end

    `TBPC_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_fire,
        $stable(r_scroll_held) && $stable(r_select_held) && $stable(r_long_sent))
    `TBPC_ASSERT_NEXT(a_scroll_freezes_select, i_clk, i_rst_n, i_fire && scroll_ev,
        $stable(r_select_held) && $stable(r_long_sent) && $stable(r_select_press_time))
    `TBPC_ASSERT_NEXT(a_long_marks_sent, i_clk, i_rst_n,
        i_fire && (o_event == EV_LONG), r_long_sent && r_select_held)

endmodule

/* rtl/two_button_press_classifier.sv */
// Pipeline: a poll is captured in the input register, and its event is then
// registered in the result register.
// Throughput: one poll per clock cycle while the output is not stalled; the debounce
// and hold compares sit between the input register and the result register.
// Reset (synchronous, active low): config registers back to their defaults, both buttons
// taken as released, pipeline empty.
`timescale 1ns / 1ps

module two_button_press_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // poll input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tbpc_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                         i_scroll_level,
    input  logic                         i_select_level,
    // event output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_event_code,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tbpc_pkg::DATA_W-1:0]  pwdata,
    output logic [tbpc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tbpc_pkg::*;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_now;
    logic              r_scroll_lvl;
    logic              r_select_lvl;
    logic              r_out_valid;
    t_event            r_out_code;

    logic              out_free;
    logic              in_free;
    logic              fire;
    logic              select_en;
    t_cfg              cfg;
    t_deb_evt          scroll_evt;
    t_deb_evt          select_evt;
    t_event            event_code;

    // Pipeline flow control
    assign out_free     = !r_out_valid || !i_out_stall;
    assign in_free      = !r_in_valid || out_free;
    assign fire         = r_in_valid && out_free;
    assign o_in_stall   = !in_free;
    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_out_code;

    tbpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbpc_debounce u_deb_scroll (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (fire),
        .i_now         (r_now),
        .i_level       (r_scroll_lvl),
        .i_debounce_ms (cfg.debounce_ms),
        .o_evt         (scroll_evt)
    );

    tbpc_debounce u_deb_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (select_en),
        .i_now         (r_now),
        .i_level       (r_select_lvl),
        .i_debounce_ms (cfg.debounce_ms),
        .o_evt         (select_evt)
    );

    tbpc_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_now       (r_now),
        .i_cfg       (cfg),
        .i_scroll    (scroll_evt),
        .i_select    (select_evt),
        .o_select_en (select_en),
        .o_event     (event_code)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_now        <= i_now_ms;
            r_scroll_lvl <= i_scroll_level;
            r_select_lvl <= i_select_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_code <= event_code;
        end
    end

endmodule
